### hw/rtl/frustum_box_cull_assert.svh
// Assertion macros for the frustum box cull checker.
// Each expects clk and arst_n in scope at the point of use.
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// implication in the same cycle
`define FBC_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define FBC_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/fbc_pkg.sv
// Shared types and constants for the frustum box cull block.
// No dependencies.
package fbc_pkg;
	localparam int NUM_REGS   = 8;
	localparam int CFG_W      = 64;
	localparam int IDX_W      = 4;
	localparam int COEF_W     = 32;
	localparam int BOX_W      = 32;
	localparam int NUM_PLANES = 6;
	localparam int NUM_COEF   = 24;
	localparam int MAG_W      = 33;
	localparam int ACC_W      = 64;
	localparam int ROOT_STEPS = 32;

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd281474976710656
	};

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [NUM_COEF-1:0] plane_bank_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SQ   = 4'b0010,
		S_ROOT = 4'b0100,
		S_DIV  = 4'b1000
	} setup_state_t;
endpackage

### hw/rtl/frustum_box_cull.sv
// Frustum box cull: tests one axis-aligned box per clock while busy is low
// against six planes from a 4x4 view-projection matrix. A box is taken when
// start is high and busy is low; its verdict appears on inside_res with done
// high, one cycle only, after the valid_s1, valid_s2, valid_s3 and done_q
// registers; the receiver cannot hold it off. After reset and after each
// register write, busy stays high while the plane set-up sequencer runs: per
// plane, squares of three components, 32 root steps and up to 4 divisions of
// FRAC_BITS+32 quotient bits. Once planes are ready, one box enters every cycle.
// Depends on fbc_pkg, fbc_setup, fbc_test.
module frustum_box_cull #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_y,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_y,
	input  logic signed [31:0] box_max_z,
	output logic               done,
	output logic               inside_res,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_idx,
	input  logic [63:0]        cfg_wdata
);
	import fbc_pkg::*;

	cfg_wr_t     cfg;
	plane_bank_t planes;
	logic        accept;

	assign cfg    = '{en: cfg_we, idx: cfg_idx, data: cfg_wdata};
	assign accept = start && !busy;

	fbc_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.busy   (busy),
		.planes (planes)
	);

	fbc_test #(.FRAC_BITS(FRAC_BITS)) u_test (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.box_min_x  (box_min_x),
		.box_min_y  (box_min_y),
		.box_min_z  (box_min_z),
		.box_max_x  (box_max_x),
		.box_max_y  (box_max_y),
		.box_max_z  (box_max_z),
		.planes     (planes),
		.done       (done),
		.inside_res (inside_res)
	);
endmodule

### hw/rtl/fbc_setup.sv
// Matrix registers and plane set-up sequencer: squares, integer root, division.
// Depends on fbc_pkg.
module fbc_setup #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fbc_pkg::cfg_wr_t    cfg,
	output logic                busy,
	output fbc_pkg::plane_bank_t planes
);
	import fbc_pkg::*;

	localparam int NUM_W  = MAG_W + FRAC_BITS - 1;
	localparam int ITER_W = $clog2(NUM_W + 1);

	logic [CFG_W-1:0]  cfg_q [NUM_REGS];
	setup_state_t      state_q;
	logic              pend_q;
	logic [2:0]        plane_q;
	logic [1:0]        comp_q;
	logic [ITER_W-1:0] iter_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  res_q;
	logic [ACC_W-1:0]  bit_q;
	logic [NUM_W-1:0]  num_q;
	logic [31:0]       rem_q;
	logic [NUM_W-1:0]  quo_q;

	logic [CFG_W-1:0]  row_lo, row_hi;
	logic signed [31:0] ent [4];
	logic signed [31:0] ent3 [4];
	logic signed [MAG_W-1:0] vsum [4];
	logic [MAG_W-1:0]  mag_c [4];
	logic              neg_c [4];
	logic [MAG_W-1:0]  cur_mag;
	logic              cur_neg;
	logic [31:0]       half;
	logic [ACC_W-1:0]  sq;
	logic [ACC_W-1:0]  trial;
	logic [32:0]       rem_n;
	logic              ge;
	logic [NUM_W-1:0]  quo_n;
	logic [31:0]       root;
	logic              wr_hit;

	function automatic coef_t sat_coef(input logic neg, input logic [NUM_W-1:0] m);
		logic big;
		big = |m[NUM_W-1:31];
		if (neg)
			sat_coef = big ? coef_t'(32'h8000_0000) : coef_t'(-{1'b0, m[30:0]});
		else
			sat_coef = big ? coef_t'(32'h7FFF_FFFF) : coef_t'({1'b0, m[30:0]});
	endfunction

	assign wr_hit = cfg.en && (cfg.idx < IDX_W'(NUM_REGS));
	assign busy = pend_q || (state_q != S_IDLE);
	assign root = res_q[31:0];

	always_comb begin
		case (plane_q[2:1])
			2'd0: begin
				row_lo = cfg_q[0];
				row_hi = cfg_q[1];
			end
			2'd1: begin
				row_lo = cfg_q[2];
				row_hi = cfg_q[3];
			end
			default: begin
				row_lo = cfg_q[4];
				row_hi = cfg_q[5];
			end
		endcase
		ent[0]  = row_lo[31:0];
		ent[1]  = row_lo[63:32];
		ent[2]  = row_hi[31:0];
		ent[3]  = row_hi[63:32];
		ent3[0] = cfg_q[6][31:0];
		ent3[1] = cfg_q[6][63:32];
		ent3[2] = cfg_q[7][31:0];
		ent3[3] = cfg_q[7][63:32];
		for (int c = 0; c < 4; c++) begin
			if (plane_q[0])
				vsum[c] = MAG_W'(ent3[c]) - MAG_W'(ent[c]);
			else
				vsum[c] = MAG_W'(ent3[c]) + MAG_W'(ent[c]);
			neg_c[c] = vsum[c][MAG_W-1];
			mag_c[c] = neg_c[c] ? MAG_W'(-vsum[c]) : MAG_W'(vsum[c]);
		end
		cur_mag = mag_c[comp_q];
		cur_neg = neg_c[comp_q];
		half    = cur_mag[MAG_W-1:1];
		sq      = ACC_W'(half) * ACC_W'(half);
		trial   = res_q + bit_q;
		rem_n   = {rem_q, num_q[NUM_W-1]};
		ge      = rem_n >= {1'b0, root};
		quo_n   = {quo_q[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_q[i] <= CFG_RESET[i];
		end else if (wr_hit) begin
			cfg_q[cfg.idx[2:0]] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b1;
			plane_q <= '0;
			comp_q  <= '0;
			iter_q  <= '0;
		end else begin
			if (wr_hit)
				pend_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						if (!wr_hit)
							pend_q <= 1'b0;
						plane_q <= '0;
						comp_q  <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (comp_q == 2'd2) begin
						comp_q  <= '0;
						iter_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end
				S_ROOT: begin
					if (iter_q == ITER_W'(ROOT_STEPS - 1)) begin
						iter_q  <= '0;
						state_q <= S_DIV;
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				S_DIV: begin
					if ((iter_q == '0 && root == '0) || iter_q == ITER_W'(NUM_W)) begin
						iter_q <= '0;
						if (comp_q == 2'd3) begin
							comp_q <= '0;
							if (plane_q == 3'(NUM_PLANES - 1)) begin
								state_q <= S_IDLE;
							end else begin
								plane_q <= plane_q + 3'd1;
								state_q <= S_SQ;
							end
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: acc_q <= '0;
			S_SQ: begin
				acc_q <= acc_q + sq + (cur_mag[0] ? ACC_W'(half) : '0);
				res_q <= '0;
				bit_q <= ACC_W'(1) << (ACC_W - 2);
			end
			S_ROOT: begin
				if (acc_q >= trial) begin
					acc_q <= acc_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV: begin
				acc_q <= '0;
				if (iter_q == '0) begin
					num_q <= NUM_W'(cur_mag) << (FRAC_BITS - 1);
					rem_q <= '0;
					quo_q <= '0;
					if (root == '0)
						planes[{plane_q, comp_q}] <= sat_coef(cur_neg, NUM_W'(cur_mag));
				end else begin
					num_q <= num_q << 1;
					rem_q <= ge ? 32'(rem_n - {1'b0, root}) : rem_n[31:0];
					quo_q <= quo_n;
					if (iter_q == ITER_W'(NUM_W))
						planes[{plane_q, comp_q}] <= sat_coef(cur_neg, quo_n);
				end
			end
			default: acc_q <= '0;
		endcase
	end
endmodule

### hw/rtl/fbc_test.sv
// Box test pipeline: corner select and products, pair sums, sign check.
// Depends on fbc_pkg.
module fbc_test #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [31:0]         box_min_x,
	input  logic signed [31:0]         box_min_y,
	input  logic signed [31:0]         box_min_z,
	input  logic signed [31:0]         box_max_x,
	input  logic signed [31:0]         box_max_y,
	input  logic signed [31:0]         box_max_z,
	input  fbc_pkg::plane_bank_t       planes,
	output logic                       done,
	output logic                       inside_res
);
	import fbc_pkg::*;

	logic                    valid_s1, valid_s2, valid_s3, done_q;
	logic signed [BOX_W-1:0] lo_s1 [3];
	logic signed [BOX_W-1:0] hi_s1 [3];
	logic signed [ACC_W-1:0] prod_s2 [NUM_PLANES][4];
	logic [ACC_W-1:0]        pair_s3 [NUM_PLANES][2];
	logic                    inside_q;

	logic signed [ACC_W-1:0] prod_d [NUM_PLANES][4];
	logic [NUM_PLANES-1:0]   neg_d;
	logic [ACC_W-1:0]        total;

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int k = 0; k < 3; k++) begin
				if (planes[p*4+k][COEF_W-1])
					prod_d[p][k] = planes[p*4+k] * lo_s1[k];
				else
					prod_d[p][k] = planes[p*4+k] * hi_s1[k];
			end
			prod_d[p][3] = ACC_W'(planes[p*4+3]) <<< FRAC_BITS;
		end
		for (int p = 0; p < NUM_PLANES; p++) begin
			total    = pair_s3[p][0] + pair_s3[p][1];
			neg_d[p] = total[ACC_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_s1[0] <= box_min_x;
			lo_s1[1] <= box_min_y;
			lo_s1[2] <= box_min_z;
			hi_s1[0] <= box_max_x;
			hi_s1[1] <= box_max_y;
			hi_s1[2] <= box_max_z;
		end
		prod_s2 <= prod_d;
		for (int p = 0; p < NUM_PLANES; p++) begin
			pair_s3[p][0] <= prod_s2[p][0] + prod_s2[p][1];
			pair_s3[p][1] <= prod_s2[p][2] + prod_s2[p][3];
		end
		inside_q <= ~|neg_d;
	end

	assign done       = done_q;
	assign inside_res = inside_q;
endmodule

### hw/rtl/fbc_checker.sv
// Port-level checks for frustum_box_cull, bound to the top level.
// Depends on frustum_box_cull_assert.svh.
`include "frustum_box_cull_assert.svh"
module fbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       cfg_we,
	input logic [3:0] cfg_idx
);
	`FBC_AST_NOW(a_word_out, start && !busy, ##4 done, "accepted word gave no result")
	`FBC_AST_NOW(a_no_ghost, done, $past(start && !busy, 4), "result without accepted word")
	`FBC_AST_NEXT(a_wr_busy, cfg_we && cfg_idx < 4'd8, busy, "register write did not start set-up")
	`FBC_AST_NOW(a_busy_src, $rose(busy), $past(cfg_we && cfg_idx < 4'd8), "busy rose without a write")
endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);
